FILE: rtl/core/cid_pkg.sv
package cid_pkg;

    // fixed field widths
    localparam int IDENT_W = 32;
    localparam int SLOT_W  = 10;
    localparam int GEN_W   = 21;

    // command codes
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_RUN    = 2'd3
    } cmd_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_BAD    = 2'd2,
        ST_FREED  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic finish;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

FILE: rtl/core/cid_ctrl.sv
module cid_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output cid_pkg::ctrl_t ctrl,
    input  cid_pkg::stat_t stat
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   finish;

    // an item finishes once the output register is free or being emptied
    assign finish   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);

    assign ctrl.clear_en = (state_reg == S_CLEAR);
    assign ctrl.accept   = (state_reg == S_IDLE) && in_valid;
    assign ctrl.finish   = finish;
    assign out_valid     = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (finish)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output word held until taken
    assign out_valid_next = finish || (out_valid_reg && out_stall);

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a finished item always shows a word next cycle
    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("finished item did not raise out_valid");

    // no item is taken while clearing
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !ctrl.accept)
        else $error("item accepted during clearing pass");

    // an accepted item leads to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

endmodule

FILE: rtl/core/cid_datapath.sv
module cid_datapath #(
    parameter int SLOT_COUNT = 1024,
    parameter int IDX_BITS   = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cid_pkg::ctrl_t               ctrl,
    output cid_pkg::stat_t               stat,
    input  logic [1:0]                   command,
    input  logic [cid_pkg::IDENT_W-1:0]  parent_ident,
    input  logic [cid_pkg::IDENT_W-1:0]  query_ident,
    input  logic                         check_permission,
    input  logic [cid_pkg::SLOT_W-1:0]   slot_select,
    output logic [1:0]                   status,
    output logic [cid_pkg::IDENT_W-1:0]  result_ident,
    output logic [cid_pkg::SLOT_W-1:0]   result_slot,
    output logic [cid_pkg::IDENT_W-1:0]  result_parent
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int IW = cid_pkg::IDENT_W;
    localparam int SW = cid_pkg::SLOT_W;
    localparam int GW = cid_pkg::GEN_W;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);
    localparam logic [IW-1:0] SLOT_LIMIT = IW'(SLOT_COUNT);
    localparam logic [IW-1:0] IDX_MASK   = IW'((64'd1 << IDX_BITS) - 64'd1);

    typedef struct packed {
        logic          in_use;
        logic [IW-1:0] ident;
        logic [IW-1:0] parent;
    } entry_t;

    // slot table and free stack
    entry_t        entry_mem [SLOT_COUNT];
    logic [AW-1:0] stack_mem [SLOT_COUNT];
    entry_t        entry_rd_reg;
    logic [AW-1:0] stack_rd_reg;

    // latched item
    cid_pkg::cmd_t cmd_reg;
    logic [IW-1:0] parent_reg;
    logic [IW-1:0] query_reg;
    logic          perm_reg;
    logic [SW-1:0] sel_reg;

    // control state
    logic [AW-1:0] clear_cnt_reg;
    logic [CW-1:0] free_count_reg;
    logic [CW-1:0] free_count_next;
    logic [GW-1:0] gen_reg;
    logic [GW-1:0] gen_next;
    logic          cur_valid_reg;
    logic          cur_valid_next;
    logic [AW-1:0] cur_slot_reg;
    logic [AW-1:0] cur_slot_next;
    logic [IW-1:0] cur_ident_reg;
    logic [IW-1:0] cur_ident_next;
    logic [IW-1:0] cur_parent_reg;
    logic [IW-1:0] cur_parent_next;

    // output word
    cid_pkg::status_t status_reg;
    cid_pkg::status_t status_next;
    logic [IW-1:0]    ident_reg;
    logic [IW-1:0]    ident_next;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    slot_next;
    logic [IW-1:0]    parent_out_reg;
    logic [IW-1:0]    parent_out_next;

    // memory port signals
    logic          entry_we;
    logic [AW-1:0] entry_waddr;
    entry_t        entry_wdata;
    logic          stack_we;
    logic [AW-1:0] stack_waddr;
    logic [AW-1:0] stack_wdata;
    logic [AW-1:0] entry_raddr;
    logic [AW-1:0] stack_raddr;

    // address decode
    logic [IW-1:0] in_qslot;
    logic [IW-1:0] in_sel_wide;
    logic [IW-1:0] qslot;
    logic [IW-1:0] sel_wide;
    logic          q_in_range;
    logic          sel_in_range;
    logic [GW-1:0] gen_inc;
    logic [63:0]   id_wide;
    logic [IW-1:0] alloc_id;
    logic [IW-1:0] alloc_slot_wide;
    logic [IW-1:0] cur_slot_wide;
    logic          lookup_bad;
    logic          perm_bad;

    assign stat.clear_last = (clear_cnt_reg == LAST_SLOT);

    // read addresses taken from the port at accept
    assign in_qslot    = query_ident & IDX_MASK;
    assign in_sel_wide = IW'(slot_select);
    assign entry_raddr = (cid_pkg::cmd_t'(command) == cid_pkg::CMD_LOOKUP) ?
                         in_qslot[AW-1:0] : in_sel_wide[AW-1:0];
    assign stack_raddr = AW'(free_count_reg - CW'(1));

    // memory reads, registered
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            entry_rd_reg <= entry_mem[entry_raddr];
            stack_rd_reg <= stack_mem[stack_raddr];
            cmd_reg      <= cid_pkg::cmd_t'(command);
            parent_reg   <= parent_ident;
            query_reg    <= query_ident;
            perm_reg     <= check_permission;
            sel_reg      <= slot_select;
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (entry_we)
            entry_mem[entry_waddr] <= entry_wdata;
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
    end

    // execute decode
    assign qslot        = query_reg & IDX_MASK;
    assign sel_wide     = IW'(sel_reg);
    assign q_in_range   = (qslot < SLOT_LIMIT);
    assign sel_in_range = (sel_wide < SLOT_LIMIT);
    assign gen_inc      = gen_reg + GW'(1);
    assign id_wide      = (64'(gen_inc) << (IDX_BITS + 1)) | 64'(stack_rd_reg);
    assign alloc_id     = id_wide[IW-1:0];
    assign alloc_slot_wide = IW'(stack_rd_reg);
    assign cur_slot_wide   = IW'(cur_slot_reg);
    assign lookup_bad   = !q_in_range || !entry_rd_reg.in_use ||
                          (entry_rd_reg.ident != query_reg);
    assign perm_bad     = perm_reg && (!cur_valid_reg ||
                          ((entry_rd_reg.ident != cur_ident_reg) &&
                           (entry_rd_reg.parent != cur_ident_reg)));

    // command execution and clearing pass
    always_comb
    begin
        entry_we        = 1'b0;
        entry_waddr     = clear_cnt_reg;
        entry_wdata     = '0;
        stack_we        = 1'b0;
        stack_waddr     = clear_cnt_reg;
        stack_wdata     = LAST_SLOT - clear_cnt_reg;
        free_count_next = free_count_reg;
        gen_next        = gen_reg;
        cur_valid_next  = cur_valid_reg;
        cur_slot_next   = cur_slot_reg;
        cur_ident_next  = cur_ident_reg;
        cur_parent_next = cur_parent_reg;
        status_next     = cid_pkg::ST_OK;
        ident_next      = '0;
        slot_next       = '0;
        parent_out_next = '0;

        if (ctrl.clear_en)
        begin
            entry_we = 1'b1;
            stack_we = 1'b1;
        end
        else if (ctrl.finish)
        begin
            case (cmd_reg)
                cid_pkg::CMD_ALLOC:
                begin
                    if (free_count_reg == '0)
                    begin
                        status_next = cid_pkg::ST_NOFREE;
                    end
                    else
                    begin
                        // pop top slot and stamp a new identifier
                        free_count_next = free_count_reg - CW'(1);
                        gen_next        = gen_inc;
                        entry_we        = 1'b1;
                        entry_waddr     = stack_rd_reg;
                        entry_wdata     = '{in_use: 1'b1, ident: alloc_id,
                                            parent: parent_reg};
                        if (stack_rd_reg == cur_slot_reg)
                        begin
                            cur_ident_next  = alloc_id;
                            cur_parent_next = parent_reg;
                        end
                        ident_next      = alloc_id;
                        slot_next       = alloc_slot_wide[SW-1:0];
                        parent_out_next = parent_reg;
                    end
                end
                cid_pkg::CMD_LOOKUP:
                begin
                    if (query_reg == '0)
                    begin
                        // current slot, no checks
                        if (cur_valid_reg)
                        begin
                            ident_next      = cur_ident_reg;
                            slot_next       = cur_slot_wide[SW-1:0];
                            parent_out_next = cur_parent_reg;
                        end
                    end
                    else if (lookup_bad || perm_bad)
                    begin
                        status_next = cid_pkg::ST_BAD;
                    end
                    else
                    begin
                        ident_next      = entry_rd_reg.ident;
                        slot_next       = qslot[SW-1:0];
                        parent_out_next = entry_rd_reg.parent;
                    end
                end
                cid_pkg::CMD_FREE:
                begin
                    slot_next = sel_reg;
                    if (!sel_in_range)
                    begin
                        status_next = cid_pkg::ST_BAD;
                    end
                    else if (!entry_rd_reg.in_use)
                    begin
                        status_next = cid_pkg::ST_FREED;
                    end
                    else
                    begin
                        // clear in-use and push the slot
                        entry_we    = 1'b1;
                        entry_waddr = sel_wide[AW-1:0];
                        entry_wdata = '{in_use: 1'b0, ident: entry_rd_reg.ident,
                                        parent: entry_rd_reg.parent};
                        if (free_count_reg < FULL_COUNT)
                        begin
                            stack_we        = 1'b1;
                            stack_waddr     = free_count_reg[AW-1:0];
                            stack_wdata     = sel_wide[AW-1:0];
                            free_count_next = free_count_reg + CW'(1);
                        end
                    end
                end
                cid_pkg::CMD_RUN:
                begin
                    slot_next = sel_reg;
                    if (!sel_in_range)
                    begin
                        status_next = cid_pkg::ST_BAD;
                    end
                    else
                    begin
                        cur_valid_next  = 1'b1;
                        cur_slot_next   = sel_wide[AW-1:0];
                        cur_ident_next  = entry_rd_reg.ident;
                        cur_parent_next = entry_rd_reg.parent;
                    end
                end
                default:
                begin
                    status_next = cid_pkg::ST_BAD;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg  <= '0;
            free_count_reg <= FULL_COUNT;
            gen_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            cur_slot_reg   <= '0;
        end
        else
        begin
            if (ctrl.clear_en)
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            free_count_reg <= free_count_next;
            gen_reg        <= gen_next;
            cur_valid_reg  <= cur_valid_next;
            cur_slot_reg   <= cur_slot_next;
        end
    end

    // current entry copy and output word
    always_ff @(posedge clk)
    begin
        cur_ident_reg  <= cur_ident_next;
        cur_parent_reg <= cur_parent_next;
        if (ctrl.finish)
        begin
            status_reg     <= status_next;
            ident_reg      <= ident_next;
            slot_reg       <= slot_next;
            parent_out_reg <= parent_out_next;
        end
    end

    assign status        = status_reg;
    assign result_ident  = ident_reg;
    assign result_slot   = slot_reg;
    assign result_parent = parent_out_reg;

    // free stack never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= FULL_COUNT)
        else $error("free count beyond slot count");

    // a successful allocate pops exactly one slot
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (cmd_reg == cid_pkg::CMD_ALLOC) && (free_count_reg != '0))
        |=> (free_count_reg == $past(free_count_reg) - CW'(1)))
        else $error("allocate did not pop one slot");

    // a current slot once set stays set
    a_cur_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |=> cur_valid_reg)
        else $error("current slot lost");

endmodule

FILE: rtl/core/context_id_table.sv
// result: the slot table's single read port is read at accept; the registered data is
//   evaluated and written back in S_EXEC, and the result word is registered once the
//   output register is free; no new item is taken until the last one finishes
// reset: after rst_n releases, a clearing pass over every slot clears the
//   in-use bits and refills the free stack; in_stall stays high during it
module context_id_table #(
    parameter int SLOT_COUNT = 1024,
    parameter int IDX_BITS   = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic [cid_pkg::IDENT_W-1:0]  parent_ident,
    input  logic [cid_pkg::IDENT_W-1:0]  query_ident,
    input  logic                         check_permission,
    input  logic [cid_pkg::SLOT_W-1:0]   slot_select,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [cid_pkg::IDENT_W-1:0]  result_ident,
    output logic [cid_pkg::SLOT_W-1:0]   result_slot,
    output logic [cid_pkg::IDENT_W-1:0]  result_parent
);

    cid_pkg::ctrl_t ctrl;
    cid_pkg::stat_t stat;

    // sequencing
    cid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // slot table, free stack and result word
    cid_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_BITS   (IDX_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .command          (command),
        .parent_ident     (parent_ident),
        .query_ident      (query_ident),
        .check_permission (check_permission),
        .slot_select      (slot_select),
        .status           (status),
        .result_ident     (result_ident),
        .result_slot      (result_slot),
        .result_parent    (result_parent)
    );

endmodule
